// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EWAH_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define EWAH_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/ewah_pkg.sv =====
// Shared types and constants of the EWAH bitmap encoder.
package ewah_pkg;

  localparam int unsigned WordBits  = 64;
  localparam int unsigned MaxWrites = 6;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_SET  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BEHIND = 2'd2
  } status_e;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_AR0   = 14'b00000000000010,
    ST_AR1   = 14'b00000000000100,
    ST_AR2   = 14'b00000000001000,
    ST_AR3   = 14'b00000000010000,
    ST_L0    = 14'b00000000100000,
    ST_L1    = 14'b00000001000000,
    ST_L2    = 14'b00000010000000,
    ST_F0    = 14'b00000100000000,
    ST_F1    = 14'b00001000000000,
    ST_SB    = 14'b00010000000000,
    ST_SV    = 14'b00100000000000,
    ST_FIN   = 14'b01000000000000,
    ST_DRAIN = 14'b10000000000000
  } seq_e;

  // Classified request as it travels from front to back.
  typedef struct packed {
    kind_e                kind;
    logic [WordBits-1:0]  word;
    logic                 word_zero;
    logic                 word_ones;
    logic                 run_value;
    logic [31:0]          run_count;
    logic [31:0]          bit_index;
  } item_t;

endpackage

// ===== rtl/ewah_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module ewah_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [1:0]        kind_i,
  input  logic [63:0]       word_i,
  input  logic              run_value_i,
  input  logic [31:0]       run_count_i,
  input  logic [31:0]       bit_index_i,
  output ewah_pkg::item_t   item_o,
  output logic              item_valid_o,
  input  logic              item_pop_i
);
  import ewah_pkg::*;

  item_t      slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t      in_item;
  logic       do_push, do_pop;

  always_comb begin
    in_item           = '0;
    in_item.kind      = kind_e'(kind_i);
    in_item.word      = word_i;
    in_item.word_zero = (word_i == '0);
    in_item.word_ones = &word_i;
    in_item.run_value = run_value_i;
    in_item.run_count = run_count_i;
    in_item.bit_index = bit_index_i;
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rp_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/ewah_back.sv =====
// Back end: step sequencer that updates the encoder state and drains buffer writes.
module ewah_back #(
  parameter int unsigned BUFFER_WORDS       = 65536,
  parameter int unsigned RUN_LENGTH_BITS    = 32,
  parameter int unsigned LITERAL_COUNT_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ewah_pkg::item_t   item_i,
  input  logic              item_valid_i,
  output logic              item_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic              write_enable_o,
  output logic [15:0]       write_address_o,
  output logic [63:0]       write_data_o,
  output logic              last_o,
  output logic [2:0]        words_added_o,
  output logic [1:0]        status_o
);
  import ewah_pkg::*;

  localparam int unsigned FW  = $clog2(BUFFER_WORDS + 1);
  localparam int unsigned RLB = RUN_LENGTH_BITS;
  localparam int unsigned LCB = LITERAL_COUNT_BITS;
  localparam logic [FW-1:0]  BufWords = FW'(BUFFER_WORDS);
  localparam logic [31:0]    RunMax   = 32'((64'd1 << RLB) - 64'd1);
  localparam logic [LCB-1:0] LitMax   = {LCB{1'b1}};

  function automatic logic [63:0] make_marker(logic rb, logic [RLB-1:0] rl,
                                              logic [LCB-1:0] lc);
    logic [63:0] m;
    m = '0;
    m[0] = rb;
    m[RLB:1] = rl;
    m[RLB+LCB:RLB+1] = lc;
    return m;
  endfunction

  // Committed state.
  logic [FW-1:0]  c_ma_q, c_fill_q;
  logic           c_rb_q;
  logic [RLB-1:0] c_rl_q;
  logic [LCB-1:0] c_lc_q;
  logic [31:0]    c_bl_q;
  logic [63:0]    c_last_q;
  // Working state.
  logic [FW-1:0]  ma_q, ma_d, fill_q, fill_d;
  logic           rb_q, rb_d;
  logic [RLB-1:0] rl_q, rl_d;
  logic [LCB-1:0] lc_q, lc_d;
  logic [31:0]    bl_q, bl_d;
  logic [63:0]    last_q, last_d;
  // Step control.
  seq_e           state_q, state_d;
  logic [31:0]    num_q, num_d;
  logic           runv_q, runv_d;
  logic           plit_q, plit_d;
  logic [63:0]    litd_q, litd_d;
  logic           fail_q, fail_d;
  status_e        stat_q, stat_d;
  // Write log.
  logic [FW-1:0]  log_addr_q [MaxWrites];
  logic [63:0]    log_data_q [MaxWrites];
  logic [2:0]     log_n_q, log_n_d;
  logic [2:0]     n_q;
  logic [2:0]     drain_q;
  logic [2:0]     added_q;
  // Emit port.
  logic           em_v;
  logic [FW-1:0]  em_addr;
  logic [63:0]    em_data;
  logic           em_hit, log_we, fail_now, step_fail;
  logic [2:0]     hit_idx, log_widx;
  // Output stage.
  logic           out_v_q, load;
  logic           commit;

  // Kind decode helpers.
  logic [32:0]    bl_word_sum;
  logic [38:0]    bl_run_sum;
  logic [32:0]    idx_sum;
  logic [26:0]    gap;
  logic [63:0]    mask, setval;
  logic [31:0]    room, can, rlw, take;

  always_comb begin
    bl_word_sum = {1'b0, c_bl_q} + 33'd64;
    bl_run_sum  = {7'b0, c_bl_q} + {1'b0, item_i.run_count, 6'b0};
    idx_sum     = {1'b0, item_i.bit_index} + 33'd1;
    gap         = ({1'b0, item_i.bit_index[31:6]} + 27'd1)
                - 27'(({1'b0, c_bl_q} + 33'd63) >> 6);
    mask        = 64'd1 << item_i.bit_index[5:0];
    setval      = c_last_q | mask;
    rlw         = 32'(rl_q);
    room        = RunMax - rlw;
    can         = (num_q < room) ? num_q : room;
    take        = (num_q >= RunMax) ? RunMax : num_q;
  end

  // Sequencer: at most one buffer write per step.
  always_comb begin
    state_d = state_q;
    ma_d = ma_q; fill_d = fill_q; rb_d = rb_q; rl_d = rl_q; lc_d = lc_q;
    bl_d = bl_q; last_d = last_q;
    num_d = num_q; runv_d = runv_q; plit_d = plit_q; litd_d = litd_q;
    fail_d = fail_q; stat_d = stat_q;
    em_v = 1'b0; em_addr = '0; em_data = '0;
    fail_now = 1'b0;
    item_pop_o = 1'b0;
    commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          ma_d = c_ma_q; fill_d = c_fill_q; rb_d = c_rb_q; rl_d = c_rl_q;
          lc_d = c_lc_q; bl_d = c_bl_q; last_d = c_last_q;
          fail_d = 1'b0; stat_d = STAT_OK; plit_d = 1'b0;
          case (item_i.kind)
            KIND_WORD: begin
              bl_d = bl_word_sum[32] ? 32'hFFFF_FFFF : bl_word_sum[31:0];
              litd_d = item_i.word;
              if (item_i.word_zero || item_i.word_ones) begin
                runv_d  = item_i.word_ones;
                state_d = ST_F0;
              end else begin
                state_d = ST_L0;
              end
            end
            KIND_RUN: begin
              if (item_i.run_count == '0) begin
                state_d = ST_FIN;
              end else begin
                bl_d = (|bl_run_sum[38:32]) ? 32'hFFFF_FFFF : bl_run_sum[31:0];
                num_d = item_i.run_count;
                runv_d = item_i.run_value;
                state_d = ST_AR0;
              end
            end
            KIND_SET: begin
              if (item_i.bit_index < c_bl_q) begin
                stat_d = STAT_BEHIND;
                state_d = ST_FIN;
              end else begin
                bl_d = idx_sum[32] ? 32'hFFFF_FFFF : idx_sum[31:0];
                litd_d = mask;
                if (gap > 27'd1) begin
                  num_d = 32'(gap - 27'd1);
                  runv_d = 1'b0;
                  plit_d = 1'b1;
                  state_d = ST_AR0;
                end else if (gap == 27'd1) begin
                  state_d = ST_L0;
                end else if (c_lc_q == '0) begin
                  // Bit lands in the word already counted by the run.
                  if (c_rl_q != '0) rl_d = c_rl_q - RLB'(1);
                  state_d = ST_L0;
                end else if (setval != '1) begin
                  litd_d = setval;
                  last_d = setval;
                  state_d = ST_SV;
                end else begin
                  // Literal became all ones: drop it and add a ones run word.
                  fill_d = c_fill_q - FW'(1);
                  lc_d = c_lc_q - LCB'(1);
                  state_d = ST_SB;
                end
              end
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_AR0: begin
        if (rb_q != runv_q && rl_q == '0 && lc_q == '0) begin
          rb_d = runv_q;
        end else if (lc_q != '0 || rb_q != runv_q) begin
          if (fill_q >= BufWords) fail_now = 1'b1;
          else begin em_v = 1'b1; em_addr = fill_q; end
          ma_d = fill_q; rl_d = '0; lc_d = '0; fill_d = fill_q + FW'(1);
          rb_d = runv_q;
        end
        state_d = ST_AR1;
      end
      ST_AR1: begin
        rl_d = RLB'(rlw + can);
        num_d = num_q - can;
        em_v = 1'b1; em_addr = ma_q;
        em_data = make_marker(rb_q, RLB'(rlw + can), lc_q);
        state_d = ST_AR2;
      end
      ST_AR2: begin
        if (num_q == '0) begin
          state_d = plit_q ? ST_L0 : ST_FIN;
        end else begin
          if (fill_q >= BufWords) fail_now = 1'b1;
          else begin em_v = 1'b1; em_addr = fill_q; end
          ma_d = fill_q; lc_d = '0; fill_d = fill_q + FW'(1);
          rb_d = runv_q;
          rl_d = RLB'(take);
          num_d = num_q - take;
          state_d = ST_AR3;
        end
      end
      ST_AR3: begin
        em_v = 1'b1; em_addr = ma_q; em_data = make_marker(rb_q, rl_q, lc_q);
        state_d = ST_AR2;
      end
      ST_L0: begin
        if (lc_q == LitMax) begin
          if (fill_q >= BufWords) fail_now = 1'b1;
          else begin em_v = 1'b1; em_addr = fill_q; end
          ma_d = fill_q; rb_d = 1'b0; rl_d = '0; fill_d = fill_q + FW'(1);
          lc_d = LCB'(1);
        end else begin
          lc_d = lc_q + LCB'(1);
        end
        state_d = ST_L1;
      end
      ST_L1: begin
        em_v = 1'b1; em_addr = ma_q; em_data = make_marker(rb_q, rl_q, lc_q);
        state_d = ST_L2;
      end
      ST_L2: begin
        if (fill_q >= BufWords) fail_now = 1'b1;
        else begin em_v = 1'b1; em_addr = fill_q; em_data = litd_q; end
        fill_d = fill_q + FW'(1);
        last_d = litd_q;
        state_d = ST_FIN;
      end
      ST_F0: begin
        if (lc_q == '0 && (rl_q == '0 || rb_q == runv_q) && rlw < RunMax) begin
          rb_d = runv_q;
          rl_d = rl_q + RLB'(1);
          em_v = 1'b1; em_addr = ma_q;
          em_data = make_marker(runv_q, rl_q + RLB'(1), lc_q);
          state_d = ST_FIN;
        end else begin
          if (fill_q >= BufWords) fail_now = 1'b1;
          else begin em_v = 1'b1; em_addr = fill_q; end
          ma_d = fill_q; lc_d = '0; fill_d = fill_q + FW'(1);
          rb_d = runv_q;
          rl_d = RLB'(1);
          state_d = ST_F1;
        end
      end
      ST_F1: begin
        em_v = 1'b1; em_addr = ma_q; em_data = make_marker(rb_q, rl_q, lc_q);
        state_d = ST_FIN;
      end
      ST_SB: begin
        em_v = 1'b1; em_addr = ma_q; em_data = make_marker(rb_q, rl_q, lc_q);
        runv_d = 1'b1;
        state_d = ST_F0;
      end
      ST_SV: begin
        em_v = 1'b1;
        em_addr = (fill_q != '0) ? fill_q - FW'(1) : '0;
        em_data = litd_q;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        commit = !fail_q;
        if (fail_q) stat_d = STAT_FULL;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (load && (n_q == '0 || drain_q == n_q - 3'd1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    step_fail = fail_now || (em_v && !em_hit && log_n_q == 3'(MaxWrites));
    if (step_fail) begin
      fail_d = 1'b1;
      state_d = ST_FIN;
    end
  end

  // Write log: a write to an address already logged replaces its data.
  always_comb begin
    em_hit = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < MaxWrites; k++) begin
      if (3'(k) < log_n_q && log_addr_q[k] == em_addr && !em_hit) begin
        em_hit = 1'b1;
        hit_idx = 3'(k);
      end
    end
    log_we   = em_v && !step_fail;
    log_widx = em_hit ? hit_idx : log_n_q;
    log_n_d  = (state_q == ST_IDLE) ? '0
             : (log_we && !em_hit) ? log_n_q + 3'd1 : log_n_q;
  end

  always_ff @(posedge clk_i) begin
    if (log_we) begin
      log_addr_q[log_widx] <= em_addr;
      log_data_q[log_widx] <= em_data;
    end
    ma_q <= ma_d; fill_q <= fill_d; rb_q <= rb_d; rl_q <= rl_d; lc_q <= lc_d;
    bl_q <= bl_d; last_q <= last_d;
    num_q <= num_d; runv_q <= runv_d; plit_q <= plit_d; litd_q <= litd_d;
  end

  // Output stage: one result per cycle while the consumer keeps up.
  logic [FW+15:0] addr_ext;
  assign load     = (state_q == ST_DRAIN) && (!out_v_q || pop_i);
  assign addr_ext = {16'b0, log_addr_q[drain_q]};
  assign empty_o  = !out_v_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (n_q == '0) begin
        write_enable_o  <= 1'b0;
        write_address_o <= '0;
        write_data_o    <= '0;
        last_o          <= 1'b1;
        words_added_o   <= added_q;
      end else begin
        write_enable_o  <= 1'b1;
        write_address_o <= addr_ext[15:0];
        write_data_o    <= log_data_q[drain_q];
        last_o          <= (drain_q == n_q - 3'd1);
        words_added_o   <= (drain_q == n_q - 3'd1) ? added_q : '0;
      end
      status_o <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fail_q   <= 1'b0;
      stat_q   <= STAT_OK;
      log_n_q  <= '0;
      n_q      <= '0;
      drain_q  <= '0;
      added_q  <= '0;
      out_v_q  <= 1'b0;
      c_ma_q   <= '0;
      c_fill_q <= FW'(1);
      c_rb_q   <= 1'b0;
      c_rl_q   <= '0;
      c_lc_q   <= '0;
      c_bl_q   <= '0;
      c_last_q <= '0;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
      stat_q  <= stat_d;
      log_n_q <= log_n_d;
      if (state_q == ST_FIN) begin
        n_q     <= fail_q ? '0 : log_n_q;
        drain_q <= '0;
        added_q <= (!fail_q && fill_q > c_fill_q) ? 3'(fill_q - c_fill_q) : '0;
      end else if (load) begin
        drain_q <= drain_q + 3'd1;
      end
      if (load)       out_v_q <= 1'b1;
      else if (pop_i) out_v_q <= 1'b0;
      if (commit) begin
        c_ma_q <= ma_q; c_fill_q <= fill_q; c_rb_q <= rb_q; c_rl_q <= rl_q;
        c_lc_q <= lc_q; c_bl_q <= bl_q; c_last_q <= last_q;
      end
    end
  end

endmodule

// ===== rtl/ewah_bitmap_encoder.sv =====
// Top level of the EWAH bitmap encoder: front queue plus step sequencer.
// The single shared step sequencer in the back end takes one request at a time and
//   finishes its steps and results before the next; a held result stalls it.
// The front queue holds two requests, so input keeps flowing while results wait.
// Reset clears the bitmap to empty: marker at word 0, fill count 1, bit length 0.
module ewah_bitmap_encoder #(
  parameter int unsigned BUFFER_WORDS       = 65536,
  parameter int unsigned RUN_LENGTH_BITS    = 32,
  parameter int unsigned LITERAL_COUNT_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request side.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [63:0] word_i,
  input  logic        run_value_i,
  input  logic [31:0] run_count_i,
  input  logic [31:0] bit_index_i,
  // Result side.
  output logic        empty,
  input  logic        pop,
  output logic        write_enable_o,
  output logic [15:0] write_address_o,
  output logic [63:0] write_data_o,
  output logic        last_o,
  output logic [2:0]  words_added_o,
  output logic [1:0]  status_o
);
  import ewah_pkg::*;

  item_t item;
  logic  item_valid, item_pop;

  // Classify and queue each request.
  ewah_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .word_i       (word_i),
    .run_value_i  (run_value_i),
    .run_count_i  (run_count_i),
    .bit_index_i  (bit_index_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // Advance the encoder state one step per cycle, hold writes until the request
  // completes, then drop them on overflow or drain them in first-write order.
  ewah_back #(
    .BUFFER_WORDS       (BUFFER_WORDS),
    .RUN_LENGTH_BITS    (RUN_LENGTH_BITS),
    .LITERAL_COUNT_BITS (LITERAL_COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .last_o          (last_o),
    .words_added_o   (words_added_o),
    .status_o        (status_o)
  );

endmodule

// ===== rtl/ewah_checker.sv =====
// Port-level checker for the EWAH bitmap encoder and its bind.
`include "assert_macros.svh"

module ewah_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        write_enable_o,
  input logic [15:0] write_address_o,
  input logic [63:0] write_data_o,
  input logic        last_o,
  input logic [2:0]  words_added_o,
  input logic [1:0]  status_o
);
  import ewah_pkg::*;

  `EWAH_ASSERT_IMP(a_nowrite_form, clk_i, rst_ni, !empty && !write_enable_o,
                   last_o && write_data_o == 64'd0 && write_address_o == 16'd0,
                   "write-less result malformed")
  `EWAH_ASSERT_IMP(a_fail_nowrite, clk_i, rst_ni, !empty && status_o != STAT_OK,
                   !write_enable_o, "failed request carries a write")
  `EWAH_ASSERT_IMP(a_added_last, clk_i, rst_ni, !empty && !last_o,
                   words_added_o == 3'd0, "words added off the last result")
  `EWAH_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop,
                   !empty && $stable(write_data_o) && $stable(write_address_o),
                   "stalled result changed")

endmodule

bind ewah_bitmap_encoder ewah_checker u_ewah_checker (.*);
